@@ hw/rtl/pip_pkg.sv @@
// Shared types and constants for the point-in-polygon tester.
// Used by pip_front, pip_back and the top level; depends on nothing else.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_BITS   = 16;
   localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int RSP_CNT_BITS = 5;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int VERTEX_BITS  = 2 * COORD_BITS;
   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEST   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [COORD_BITS-1:0]  x_coord;
      logic signed [COORD_BITS-1:0]  y_coord;
   } req_payload_type;

   typedef struct packed {
      logic                          inside_res;
      logic [RSP_CNT_BITS-1:0]       left_crossings;
      logic [RSP_CNT_BITS-1:0]       vertex_count;
   } rsp_payload_type;

   typedef struct packed {
      kind_type                      op;
      logic signed [COORD_BITS-1:0]  x_coord;
      logic signed [COORD_BITS-1:0]  y_coord;
   } cmd_type;

endpackage

@@ hw/rtl/pip_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pip_front.sv @@
// Front end: takes request words, drops unused kinds, queues commands.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  pip_pkg::req_payload_type req_payload,
   output logic                     cmd_valid,
   output pip_pkg::cmd_type         cmd,
   input  logic                     cmd_pop
);

   pip_pkg::cmd_type                    q_ff [pip_pkg::CMD_DEPTH];
   logic [pip_pkg::CMD_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pip_pkg::CMD_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pip_pkg::CMD_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                                keep;
   logic                                push_en;
   logic                                pop_en;
   pip_pkg::cmd_type                    entry_in;

   assign req_full  = (cnt_ff == pip_pkg::CMD_CNT_BITS'(pip_pkg::CMD_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      keep = req_payload.kind inside {pip_pkg::KIND_CLEAR, pip_pkg::KIND_APPEND,
                                      pip_pkg::KIND_TEST};
      push_en = req_push && !req_full && keep;
      pop_en  = cmd_pop && cmd_valid;

      entry_in.op      = pip_pkg::kind_type'(req_payload.kind);
      entry_in.x_coord = req_payload.x_coord;
      entry_in.y_coord = req_payload.y_coord;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == pip_pkg::CMD_PTR_BITS'(pip_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == pip_pkg::CMD_PTR_BITS'(pip_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ hw/rtl/pip_back.sv @@
// Back end: runs clear, append and test commands against the vertex store
// and holds the result word. Depends on pip_pkg and pip_ram.
`timescale 1ns / 1ps

module pip_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  pip_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pip_pkg::rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type                           state_ff, state_in;
   logic [pip_pkg::CNT_BITS-1:0]        count_ff, count_in;
   logic                                out_valid_ff, out_valid_in;
   pip_pkg::rsp_payload_type            out_ff, out_in;
   logic                                b_valid_ff, b_valid_in;
   logic                                c_valid_ff, c_valid_in;

   logic [pip_pkg::CNT_BITS-1:0]        n_ff, n_in;
   logic [pip_pkg::CNT_BITS-1:0]        idx_ff, idx_in;
   logic signed [pip_pkg::COORD_BITS-1:0] qx_ff, qx_in;
   logic signed [pip_pkg::COORD_BITS-1:0] qy_ff, qy_in;
   logic                                b_prime_ff, b_prime_in;
   logic                                b_last_ff, b_last_in;
   logic signed [pip_pkg::COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [pip_pkg::COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                                c_last_ff, c_last_in;
   logic                                c_straddle_ff, c_straddle_in;
   logic                                c_dypos_ff, c_dypos_in;
   logic signed [pip_pkg::PROD_BITS-1:0] lhs_ff, lhs_in;
   logic signed [pip_pkg::PROD_BITS-1:0] rhs_ff, rhs_in;
   logic [pip_pkg::CNT_BITS-1:0]        left_ff, left_in;

   logic                                out_free;
   logic                                issue;
   logic                                wr_en;
   logic [pip_pkg::ADDR_BITS-1:0]       wr_addr;
   logic [pip_pkg::VERTEX_BITS-1:0]     wr_data;
   logic [pip_pkg::ADDR_BITS-1:0]       rd_addr;
   logic [pip_pkg::VERTEX_BITS-1:0]     rd_data;
   logic signed [pip_pkg::COORD_BITS-1:0] cur_x;
   logic signed [pip_pkg::COORD_BITS-1:0] cur_y;
   logic signed [pip_pkg::DIFF_BITS-1:0] d_qy_yi;
   logic signed [pip_pkg::DIFF_BITS-1:0] d_xi_xj;
   logic signed [pip_pkg::DIFF_BITS-1:0] d_qx_xi;
   logic signed [pip_pkg::DIFF_BITS-1:0] d_yi_yj;
   logic                                hit;
   logic [pip_pkg::CNT_BITS-1:0]        left_next;

   pip_ram #(
      .WIDTH (pip_pkg::VERTEX_BITS),
      .DEPTH (pip_pkg::MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;
   assign wr_addr     = count_ff[pip_pkg::ADDR_BITS-1:0];
   assign wr_data     = {cmd.x_coord, cmd.y_coord};
   assign cur_x       = rd_data[pip_pkg::VERTEX_BITS-1:pip_pkg::COORD_BITS];
   assign cur_y       = rd_data[pip_pkg::COORD_BITS-1:0];

   // First read of a walk fetches the last vertex, then vertices in order.
   assign rd_addr = (idx_ff == '0) ? pip_pkg::ADDR_BITS'(n_ff - 1'b1)
                                   : pip_pkg::ADDR_BITS'(idx_ff - 1'b1);

   // Edge stage: current vertex is i, the previous one read is j.
   always_comb begin
      d_qy_yi = pip_pkg::DIFF_BITS'(qy_ff) - pip_pkg::DIFF_BITS'(cur_y);
      d_xi_xj = pip_pkg::DIFF_BITS'(cur_x) - pip_pkg::DIFF_BITS'(prev_x_ff);
      d_qx_xi = pip_pkg::DIFF_BITS'(qx_ff) - pip_pkg::DIFF_BITS'(cur_x);
      d_yi_yj = pip_pkg::DIFF_BITS'(cur_y) - pip_pkg::DIFF_BITS'(prev_y_ff);

      c_straddle_in = ((cur_y < qy_ff) && (prev_y_ff >= qy_ff)) ||
                      ((prev_y_ff < qy_ff) && (cur_y >= qy_ff));
      c_dypos_in    = (cur_y > prev_y_ff);
      lhs_in        = d_qy_yi * d_xi_xj;
      rhs_in        = d_qx_xi * d_yi_yj;
      c_last_in     = b_last_ff;
      c_valid_in    = b_valid_ff && !b_prime_ff;

      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (b_valid_ff) begin
         prev_x_in = cur_x;
         prev_y_in = cur_y;
      end
   end

   // Compare stage: the sign of dy picks the direction of the test.
   always_comb begin
      hit = c_straddle_ff && (c_dypos_ff ? (lhs_ff <= rhs_ff) : (lhs_ff >= rhs_ff));
      left_next = left_ff + pip_pkg::CNT_BITS'(hit);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      out_free     = !out_valid_ff || rsp_pop;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      issue        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  pip_pkg::KIND_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                  end
                  pip_pkg::KIND_APPEND: begin
                     cmd_pop = 1'b1;
                     // drop the vertex when the store is full
                     if (count_ff < pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pip_pkg::KIND_TEST: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        n_in    = count_ff;
                        qx_in   = cmd.x_coord;
                        qy_in   = cmd.y_coord;
                        left_in = '0;
                        idx_in  = '0;
                        if (count_ff == '0) begin
                           out_valid_in          = 1'b1;
                           out_in.inside_res     = 1'b0;
                           out_in.left_crossings = '0;
                           out_in.vertex_count   = '0;
                        end else begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            issue  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (c_valid_ff && c_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (c_valid_ff) begin
         left_in = left_next;
         if (c_last_ff) begin
            out_valid_in          = 1'b1;
            out_in.inside_res     = left_next[0];
            out_in.left_crossings = pip_pkg::RSP_CNT_BITS'(left_next);
            out_in.vertex_count   = pip_pkg::RSP_CNT_BITS'(n_ff);
         end
      end

      b_valid_in = issue;
      b_prime_in = (idx_ff == '0);
      b_last_in  = (idx_ff == n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      b_prime_ff    <= b_prime_in;
      b_last_ff     <= b_last_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      c_last_ff     <= c_last_in;
      c_straddle_ff <= c_straddle_in;
      c_dypos_ff    <= c_dypos_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      left_ff       <= left_in;
   end

endmodule

@@ hw/rtl/point_in_polygon_test.sv @@
// Even-odd point-in-polygon tester, top level. Depends on pip_pkg, pip_front, pip_back.
// Clear and append pass through the back end without a walk; a test of n > 0 vertices holds the
// back end while it takes the command, makes n + 1 store reads, then multiplies and compares.
// A test on an empty store gives an all-zero result word without a walk; a four-word command
// queue decouples the two ends.
// Synchronous reset empties the queue, the result word and the vertex count, not the store.
`timescale 1ns / 1ps

module point_in_polygon_test (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  pip_pkg::req_payload_type req_payload,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pip_pkg::rsp_payload_type rsp_payload
);

   logic             cmd_valid;
   logic             cmd_pop;
   pip_pkg::cmd_type cmd;

   pip_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   pip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule
